>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the segmented callback queue.
// Both expect clk_i and rst_ni to be visible at the place of use.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SBCQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A condition that must never be seen outside reset.
`define SBCQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

>>> design/sbcq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbcq_pkg
// Types, codes and constants of the segmented batch callback queue.
// ---------------------------------------------------------------------------
package sbcq_pkg;

  // Default geometry of the queue.
  localparam int NUM_SEGMENTS_DEF = 4;
  localparam int SEG_SLOTS_DEF    = 64;
  localparam int MAX_BATCH_DEF    = 16;

  // Field widths.
  localparam int HANDLE_W = 32;
  localparam int STAMP_W  = 32;
  localparam int CFG_W    = 5;

  // Reset value of the batch limit register.
  localparam logic [CFG_W-1:0] BATCH_LIMIT_RESET = 5'd16;

  // A tick never yields more than this many items.
  localparam int RESULT_LIMIT = 64;
  localparam int RES_CNT_W    = $clog2(RESULT_LIMIT + 1);

  // Input action codes.
  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  // Result kind codes.
  localparam logic KIND_ACK      = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

  // Life cycle of a segment.
  typedef enum logic [1:0] {
    SEG_FREE   = 2'd0,
    SEG_OPEN   = 2'd1,
    SEG_SEALED = 2'd2
  } seg_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // take the input item
    logic seal;      // seal the current segment if it is at capacity
    logic enq;       // store the handle and load the acknowledgment
    logic sel_scan;  // segment tables looked up at the scan index
    logic issue;     // read the oldest handle of the scanned segment
    logic capt;      // move the read handle into the pending slot
    logic next_seg;  // close the scanned segment and move on
    logic finish;    // bump the grace counter and flush the pending slot
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;      // output register can be loaded this cycle
    logic pend_valid;    // a dispatched handle waits in the pending slot
    logic can_dispatch;  // scanned segment may give one more handle
    logic scan_last;     // scan index is at the last segment
  } stat_t;

endpackage

>>> design/sbcq_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbcq_in_if
// Input channel of the callback queue: one action with its handle per item.
// ---------------------------------------------------------------------------
interface sbcq_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [sbcq_pkg::HANDLE_W-1:0] handle;

  modport source (output valid, output action, output handle, input ready);
  modport sink   (input valid, input action, input handle, output ready);
endinterface

>>> design/sbcq_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbcq_out_if
// Result channel of the callback queue: acknowledgments and dispatches.
// ---------------------------------------------------------------------------
interface sbcq_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic                          accepted;
  logic [sbcq_pkg::HANDLE_W-1:0] out_handle;
  logic [sbcq_pkg::STAMP_W-1:0]  stamp;
  logic                          last;

  modport source (output valid, output kind, output accepted, output out_handle,
                  output stamp, output last, input ready);
  modport sink   (input valid, input kind, input accepted, input out_handle,
                  input stamp, input last, output ready);
endinterface

>>> design/sbcq_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbcq_datapath
// Handle and stamp memories, per-segment tables, grace counter, pending
// slot and output register of the callback queue.
// ---------------------------------------------------------------------------
module sbcq_datapath #(
  parameter int NUM_SEGMENTS = sbcq_pkg::NUM_SEGMENTS_DEF,
  parameter int SEG_SLOTS    = sbcq_pkg::SEG_SLOTS_DEF,
  parameter int MAX_BATCH    = sbcq_pkg::MAX_BATCH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sbcq_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic [sbcq_pkg::HANDLE_W-1:0] in_handle_i,
  input  logic                          out_ready_i,
  input  sbcq_pkg::cmd_t                cmd_i,
  output sbcq_pkg::stat_t               stat_o,
  output logic                          out_valid_o,
  output logic                          out_kind_o,
  output logic                          out_accepted_o,
  output logic [sbcq_pkg::HANDLE_W-1:0] out_handle_o,
  output logic [sbcq_pkg::STAMP_W-1:0]  out_stamp_o,
  output logic                          out_last_o
);

  localparam int SegW  = $clog2(NUM_SEGMENTS);
  localparam int SlotW = $clog2(SEG_SLOTS);
  localparam int CntW  = $clog2(SEG_SLOTS + 1);
  localparam int Depth = NUM_SEGMENTS * SEG_SLOTS;
  localparam int AddrW = $clog2(Depth);
  localparam int DoneW = $clog2(MAX_BATCH + 1);
  localparam int LimW  = (DoneW > sbcq_pkg::CFG_W) ? DoneW : sbcq_pkg::CFG_W;
  localparam int HW    = sbcq_pkg::HANDLE_W;
  localparam int SW    = sbcq_pkg::STAMP_W;

  // Configuration and control registers.
  logic [sbcq_pkg::CFG_W-1:0] batch_limit_q;
  logic [SegW-1:0]            cur_seg_q;
  logic [SegW-1:0]            scan_q;
  logic [DoneW-1:0]           done_q;
  logic [sbcq_pkg::RES_CNT_W-1:0] n_q;
  logic [SW-1:0]              grace_q;
  logic                       pend_valid_q;
  logic                       out_valid_q;

  // Segment tables.
  logic [SlotW-1:0]           seg_head_q   [NUM_SEGMENTS];
  logic [SlotW-1:0]           seg_tail_q   [NUM_SEGMENTS];
  logic [CntW-1:0]            seg_count_q  [NUM_SEGMENTS];
  sbcq_pkg::seg_status_e      seg_status_q [NUM_SEGMENTS];

  // Payload registers and memories.
  logic [HW-1:0]              handle_q;
  logic [HW-1:0]              pend_handle_q;
  logic [SW-1:0]              pend_stamp_q;
  logic [HW-1:0]              rd_handle_q;
  logic [SW-1:0]              rd_stamp_q;
  logic                       out_kind_q;
  logic                       out_accepted_q;
  logic [HW-1:0]              out_handle_q;
  logic [SW-1:0]              out_stamp_q;
  logic                       out_last_q;
  logic [HW-1:0]              handle_mem [Depth];
  logic [SW-1:0]              stamp_mem  [Depth];

  // Combinational views.
  logic [SegW-1:0]            sel;
  logic [SlotW-1:0]           sel_head;
  logic [SlotW-1:0]           sel_tail;
  logic [CntW-1:0]            sel_count;
  sbcq_pkg::seg_status_e      sel_status;
  sbcq_pkg::seg_status_e      enq_status;
  logic                       seal_hit;
  logic                       enq_ok;
  logic [SegW-1:0]            cur_nxt;
  logic [SegW-1:0]            scan_nxt;
  logic [SlotW-1:0]           head_nxt;
  logic [SlotW-1:0]           tail_nxt;
  logic [AddrW-1:0]           seg_base;
  logic [AddrW-1:0]           wr_addr;
  logic [AddrW-1:0]           rd_addr;
  logic [LimW-1:0]            lim_raw;
  logic [LimW-1:0]            lim_clamped;
  logic [DoneW-1:0]           lim;
  logic                       out_free;

  // One lookup port into the segment tables, at the current or scanned segment.
  assign sel        = cmd_i.sel_scan ? scan_q : cur_seg_q;
  assign sel_head   = seg_head_q[sel];
  assign sel_tail   = seg_tail_q[sel];
  assign sel_count  = seg_count_q[sel];
  assign sel_status = seg_status_q[sel];

  // Ring arithmetic for segment indices and slot pointers.
  assign cur_nxt  = (cur_seg_q == SegW'(NUM_SEGMENTS - 1)) ? '0 : cur_seg_q + 1'b1;
  assign scan_nxt = (scan_q == SegW'(NUM_SEGMENTS - 1)) ? '0 : scan_q + 1'b1;
  assign head_nxt = (sel_head == SlotW'(SEG_SLOTS - 1)) ? '0 : sel_head + 1'b1;
  assign tail_nxt = (sel_tail == SlotW'(SEG_SLOTS - 1)) ? '0 : sel_tail + 1'b1;

  // Memory addresses: segment base plus slot pointer.
  assign seg_base = AddrW'(sel) * AddrW'(SEG_SLOTS);
  assign wr_addr  = seg_base + AddrW'(sel_tail);
  assign rd_addr  = seg_base + AddrW'(sel_head);

  // A segment still filling but at capacity is sealed by the next enqueue.
  assign seal_hit = (sel_count >= CntW'(SEG_SLOTS)) &&
                    (sel_status == sbcq_pkg::SEG_OPEN);

  // An empty segment starts filling; only a filling segment with room stores.
  assign enq_status = (sel_status == sbcq_pkg::SEG_FREE) ? sbcq_pkg::SEG_OPEN
                                                         : sel_status;
  assign enq_ok     = (enq_status == sbcq_pkg::SEG_OPEN) &&
                      (sel_count < CntW'(SEG_SLOTS));

  // Batch limit with zero read as one and large values capped.
  assign lim_raw     = LimW'(batch_limit_q);
  assign lim_clamped = (lim_raw == '0) ? LimW'(1) :
                       (lim_raw > LimW'(MAX_BATCH)) ? LimW'(MAX_BATCH) : lim_raw;
  assign lim         = DoneW'(lim_clamped);

  assign out_free = !out_valid_q || out_ready_i;

  // Status towards the controller.
  always_comb begin
    stat_o.out_free     = out_free;
    stat_o.pend_valid   = pend_valid_q;
    stat_o.can_dispatch = (sel_status == sbcq_pkg::SEG_SEALED) && (sel_count != '0) &&
                          (done_q < lim) &&
                          (n_q < sbcq_pkg::RES_CNT_W'(sbcq_pkg::RESULT_LIMIT));
    stat_o.scan_last    = (scan_q == SegW'(NUM_SEGMENTS - 1));
  end

  // Batch limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_limit_q <= sbcq_pkg::BATCH_LIMIT_RESET;
    end else if (cfg_we_i) begin
      batch_limit_q <= cfg_wdata_i;
    end
  end

  // Segment tables and the current segment pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SEGMENTS; i++) begin
        seg_head_q[i]   <= '0;
        seg_tail_q[i]   <= '0;
        seg_count_q[i]  <= '0;
        seg_status_q[i] <= sbcq_pkg::SEG_FREE;
      end
      cur_seg_q <= '0;
    end else begin
      if (cmd_i.seal && seal_hit) begin
        seg_status_q[sel] <= sbcq_pkg::SEG_SEALED;
        cur_seg_q         <= cur_nxt;
      end
      if (cmd_i.enq) begin
        seg_status_q[sel] <= enq_status;
        if (enq_ok) begin
          seg_tail_q[sel]  <= tail_nxt;
          seg_count_q[sel] <= sel_count + 1'b1;
        end
      end
      if (cmd_i.issue) begin
        seg_head_q[sel]  <= head_nxt;
        seg_count_q[sel] <= sel_count - 1'b1;
      end
      if (cmd_i.next_seg && (sel_count == '0)) begin
        seg_status_q[sel] <= sbcq_pkg::SEG_FREE;
        seg_head_q[sel]   <= '0;
        seg_tail_q[sel]   <= '0;
      end
    end
  end

  // Scan position, per-segment batch count and per-tick result count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      done_q <= '0;
      n_q    <= '0;
    end else begin
      if (cmd_i.accept) begin
        scan_q <= '0;
        done_q <= '0;
        n_q    <= '0;
      end
      if (cmd_i.issue) begin
        done_q <= done_q + 1'b1;
        n_q    <= n_q + 1'b1;
      end
      if (cmd_i.next_seg) begin
        scan_q <= scan_nxt;
        done_q <= '0;
      end
    end
  end

  // Grace counter, bumped once per tick and wrapping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grace_q <= '0;
    end else if (cmd_i.finish) begin
      grace_q <= grace_q + 1'b1;
    end
  end

  // Handle and stamp memories; the read is taken only when a handle is issued.
  always_ff @(posedge clk_i) begin
    if (cmd_i.enq && enq_ok) begin
      handle_mem[wr_addr] <= handle_q;
      stamp_mem[wr_addr]  <= grace_q;
    end
    if (cmd_i.issue) begin
      rd_handle_q <= handle_mem[rd_addr];
      rd_stamp_q  <= stamp_mem[rd_addr];
    end
  end

  // Valid flags of the pending slot and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.capt) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.finish) begin
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.enq || ((cmd_i.capt || cmd_i.finish) && pend_valid_q)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload of the input latch, pending slot and output register.
  // A dispatch is held back in the pending slot so that the final one can carry last.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      handle_q <= in_handle_i;
    end
    if (cmd_i.enq) begin
      out_kind_q     <= sbcq_pkg::KIND_ACK;
      out_accepted_q <= enq_ok;
      out_handle_q   <= '0;
      out_stamp_q    <= '0;
      out_last_q     <= 1'b1;
    end
    if ((cmd_i.capt || cmd_i.finish) && pend_valid_q) begin
      out_kind_q     <= sbcq_pkg::KIND_DISPATCH;
      out_accepted_q <= 1'b0;
      out_handle_q   <= pend_handle_q;
      out_stamp_q    <= pend_stamp_q;
      out_last_q     <= cmd_i.finish;
    end
    if (cmd_i.capt) begin
      pend_handle_q <= rd_handle_q;
      pend_stamp_q  <= rd_stamp_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_kind_q;
  assign out_accepted_o = out_accepted_q;
  assign out_handle_o   = out_handle_q;
  assign out_stamp_o    = out_stamp_q;
  assign out_last_o     = out_last_q;

endmodule

>>> design/sbcq_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbcq_ctrl
// Sequencer of the callback queue: takes items, runs an enqueue or walks the
// segments of a tick, and paces both against the output register.
// ---------------------------------------------------------------------------
module sbcq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_action_i,
  output logic            in_ready_o,
  input  sbcq_pkg::stat_t stat_i,
  output sbcq_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ENQ  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_CAPT = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_action_i == sbcq_pkg::ACT_TICK) begin
            state_d = S_SCAN;
          end else begin
            // Lazy seal of the current segment happens as the item comes in.
            cmd_o.seal = 1'b1;
            state_d    = S_ENQ;
          end
        end
      end
      S_ENQ: begin
        if (stat_i.out_free) begin
          cmd_o.enq = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.sel_scan = 1'b1;
        if (stat_i.can_dispatch) begin
          cmd_o.issue = 1'b1;
          state_d     = S_CAPT;
        end else begin
          cmd_o.next_seg = 1'b1;
          if (stat_i.scan_last) begin
            state_d = S_FIN;
          end
        end
      end
      S_CAPT: begin
        cmd_o.sel_scan = 1'b1;
        if (!stat_i.pend_valid || stat_i.out_free) begin
          cmd_o.capt = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_FIN: begin
        cmd_o.sel_scan = 1'b1;
        if (!stat_i.pend_valid || stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/segmented_batch_callback_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// segmented_batch_callback_queue
// Ring of segments holding callback handles, sealed lazily and drained in
// batches on each grace period tick.
// ---------------------------------------------------------------------------
// An enqueue accepts the item (and seals a full current segment), then writes
// the handle memory and loads the acknowledgment. A tick runs through the
// accept step, one closing step per segment, a read and a capture step per
// dispatched handle through the handle memory, and a final step that bumps
// the grace counter and sends the held-back dispatch, if any, as the last
// item. Steps that load the output register wait while it is held by the
// sink. The handle and stamp memories are not cleared after reset; only
// entries written by an enqueue are ever read, so the block accepts items
// from the first cycle.
module segmented_batch_callback_queue #(
  parameter int NUM_SEGMENTS = sbcq_pkg::NUM_SEGMENTS_DEF,
  parameter int SEG_SLOTS    = sbcq_pkg::SEG_SLOTS_DEF,
  parameter int MAX_BATCH    = sbcq_pkg::MAX_BATCH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sbcq_pkg::CFG_W-1:0] cfg_wdata_i,
  sbcq_in_if.sink                    in_i,
  sbcq_out_if.source                 out_o
);

  `include "assert_macros.svh"

  sbcq_pkg::cmd_t  cmd;
  sbcq_pkg::stat_t stat;

  // Sequencer.
  sbcq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Storage and result path.
  sbcq_datapath #(
    .NUM_SEGMENTS (NUM_SEGMENTS),
    .SEG_SLOTS    (SEG_SLOTS),
    .MAX_BATCH    (MAX_BATCH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_handle_i    (in_i.handle),
    .out_ready_i    (out_o.ready),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_o.valid),
    .out_kind_o     (out_o.kind),
    .out_accepted_o (out_o.accepted),
    .out_handle_o   (out_o.out_handle),
    .out_stamp_o    (out_o.stamp),
    .out_last_o     (out_o.last)
  );

  // Every tick flushes its held-back dispatch before a new item is taken.
  `SBCQ_ASSERT(a_idle_no_pending, in_i.ready |-> !stat.pend_valid, "pending item left after tick")

  // A held-back dispatch is only replaced when the output register can take it.
  `SBCQ_ASSERT(a_pending_not_lost, (cmd.capt && stat.pend_valid) |-> stat.out_free, "pending item overwritten")

  // An acknowledgment is always final and carries no handle or stamp.
  `SBCQ_ASSERT_NEVER(a_ack_payload, out_o.valid && (out_o.kind == sbcq_pkg::KIND_ACK) && (!out_o.last || (out_o.out_handle != '0) || (out_o.stamp != '0)), "malformed acknowledgment")

endmodule
